### rtl/core/prime_factorizer_macros.svh
// Assertion macros shared by the prime factorizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PRIME_FACTORIZER_MACROS_SVH
`define PRIME_FACTORIZER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/pf_pkg.sv
// Package for the prime factorizer: field widths, microcode codes and the
// microprogram itself. No dependencies.
`timescale 1ns / 1ps

package pf_pkg;

  localparam int IN_W     = 32;
  localparam int FACTOR_W = 32;
  localparam int UPC_W    = 4;

  // datapath actions
  localparam logic [2:0] ACT_NOP       = 3'd0;
  localparam logic [2:0] ACT_LOAD      = 3'd1;
  localparam logic [2:0] ACT_DIV_GO    = 3'd2;
  localparam logic [2:0] ACT_INC_DIV   = 3'd3;
  localparam logic [2:0] ACT_EMIT_DIV  = 3'd4;
  localparam logic [2:0] ACT_EMIT_NONE = 3'd5;
  localparam logic [2:0] ACT_EMIT_REM  = 3'd6;

  // hold conditions: the step stalls until its wait is met
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_IN   = 2'd1;
  localparam logic [1:0] WAIT_DIV  = 2'd2;
  localparam logic [1:0] WAIT_OUT  = 2'd3;

  // jump conditions
  localparam logic [2:0] COND_NEVER      = 3'd0;
  localparam logic [2:0] COND_ALWAYS     = 3'd1;
  localparam logic [2:0] COND_REM_LE1    = 3'd2;
  localparam logic [2:0] COND_DIV_GT_QUO = 3'd3;
  localparam logic [2:0] COND_MOD_ZERO   = 3'd4;

  // microprogram step addresses
  localparam logic [UPC_W-1:0] STEP_FETCH     = 4'd0;
  localparam logic [UPC_W-1:0] STEP_SMALL     = 4'd1;
  localparam logic [UPC_W-1:0] STEP_DSTART    = 4'd2;
  localparam logic [UPC_W-1:0] STEP_DWAIT     = 4'd3;
  localparam logic [UPC_W-1:0] STEP_MODTEST   = 4'd4;
  localparam logic [UPC_W-1:0] STEP_INC       = 4'd5;
  localparam logic [UPC_W-1:0] STEP_EMIT_DIV  = 4'd6;
  localparam logic [UPC_W-1:0] STEP_EMIT_NONE = 4'd7;
  localparam logic [UPC_W-1:0] STEP_EMIT_REM  = 4'd8;

  typedef struct packed {
    logic [2:0]       act;
    logic [1:0]       wt;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic [2:0] act;
    logic       take;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_free;
    logic div_busy;
    logic rem_le1;
    logic div_gt_quo;
    logic mod_zero;
  } stat_t;

  // Control store. Falls through to the next step unless the jump is taken.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      STEP_FETCH:     w = '{ACT_LOAD,      WAIT_IN,   COND_NEVER,      STEP_FETCH};
      STEP_SMALL:     w = '{ACT_NOP,       WAIT_NONE, COND_REM_LE1,    STEP_EMIT_NONE};
      STEP_DSTART:    w = '{ACT_DIV_GO,    WAIT_NONE, COND_NEVER,      STEP_FETCH};
      STEP_DWAIT:     w = '{ACT_NOP,       WAIT_DIV,  COND_DIV_GT_QUO, STEP_EMIT_REM};
      STEP_MODTEST:   w = '{ACT_NOP,       WAIT_NONE, COND_MOD_ZERO,   STEP_EMIT_DIV};
      STEP_INC:       w = '{ACT_INC_DIV,   WAIT_NONE, COND_ALWAYS,     STEP_DSTART};
      STEP_EMIT_DIV:  w = '{ACT_EMIT_DIV,  WAIT_OUT,  COND_ALWAYS,     STEP_DSTART};
      STEP_EMIT_NONE: w = '{ACT_EMIT_NONE, WAIT_OUT,  COND_ALWAYS,     STEP_FETCH};
      STEP_EMIT_REM:  w = '{ACT_EMIT_REM,  WAIT_OUT,  COND_ALWAYS,     STEP_FETCH};
      default:        w = '{ACT_NOP,       WAIT_NONE, COND_ALWAYS,     STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/pf_chan_if.sv
// Valid/ready channel interfaces for the prime factorizer input and result.
// Depends on pf_pkg for the field widths.
`timescale 1ns / 1ps

interface pf_in_if;
  logic                       valid;
  logic                       ready;
  logic [pf_pkg::IN_W-1:0]    value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface pf_out_if;
  logic                        valid;
  logic                        ready;
  logic [pf_pkg::FACTOR_W-1:0] factor;
  logic                        last;
  logic                        none;

  modport source (output valid, output factor, output last, output none, input ready);
  modport sink   (input valid, input factor, input last, input none, output ready);
endinterface

### rtl/core/prime_factorizer.sv
// Prime factorizer top level: trial division under microcode control.
// Depends on pf_pkg, pf_chan_if, pf_seq, pf_dp (and pf_divu below it).
//
// Use: in_chan takes one unsigned 32-bit word (value_in), reduced to its low
// WIDTH bits. out_chan returns its prime factors, smallest first, repeated by
// multiplicity, one per word; the final word of a run has last set. An input
// of 0 or 1 gives a single word with none and last set and factor zero.
// One input is worked on at a time: in_chan.ready is high only while the
// sequencer waits at its fetch step.
// Each trial divisor costs one restoring division on the shared divider
// plus four control steps (start, wait, mod test, increment); each factor
// found costs one division, three control steps and its emit step.
// Results leave through a single output register; while the receiver stalls
// the sequencer holds at its emit step and the word stays on out_chan.
// Reset (rst_n low, synchronous) returns the sequencer to fetch and empties
// the output register; any run in progress is dropped.
`timescale 1ns / 1ps

module prime_factorizer #(
  parameter int WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  pf_in_if.sink    in_chan,
  pf_out_if.source out_chan
);

  // the input word is 32 bits, so nothing wider is ever needed
  localparam int NW = (WIDTH < pf_pkg::IN_W) ? WIDTH : pf_pkg::IN_W;

  pf_pkg::ctl_t  ctl;
  pf_pkg::stat_t stat;

  pf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  pf_dp #(.NW(NW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .value_in  (in_chan.value_in),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .factor    (out_chan.factor),
    .last      (out_chan.last),
    .none      (out_chan.none),
    .stat      (stat)
  );

  assign in_chan.ready = ctl.take;

endmodule

### rtl/core/pf_divu.sv
// Restoring divider, one quotient bit per cycle.
// Depends on prime_factorizer_macros.svh.
`timescale 1ns / 1ps
`include "prime_factorizer_macros.svh"

module pf_divu #(
  parameter int NW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [NW-1:0] rmd
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] part_r, part_nxt;
  logic [NW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          ge;

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rmd  = part_r;

  // one shift-subtract step
  always_comb begin
    trial = {part_r, quo_r[NW-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    quo_nxt  = quo_r;
    part_nxt = part_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    if (go) begin
      quo_nxt  = dividend;
      part_nxt = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(NW);
    end else if (busy) begin
      quo_nxt  = {quo_r[NW-2:0], ge};
      part_nxt = ge ? diff[NW-1:0] : trial[NW-1:0];
      cnt_nxt  = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    part_r <= part_nxt;
    dvs_r  <= dvs_nxt;
  end

  `PF_ASSERT_NOW(a_go_when_idle, clk, rst_n, go, !busy, "divider started while busy")
  `PF_ASSERT_NOW(a_divisor_nz, clk, rst_n, go, divisor != '0, "division by zero started")

endmodule

### rtl/core/pf_dp.sv
// Datapath of the prime factorizer: remainder and trial divisor registers,
// divider and result register. Depends on pf_pkg, pf_divu, macros header.
`timescale 1ns / 1ps
`include "prime_factorizer_macros.svh"

module pf_dp #(
  parameter int NW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pf_pkg::ctl_t                ctl,
  input  logic [pf_pkg::IN_W-1:0]     value_in,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pf_pkg::FACTOR_W-1:0] factor,
  output logic                        last,
  output logic                        none,
  output pf_pkg::stat_t               stat
);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] div_r, div_nxt;
  logic [NW-1:0] quo;
  logic [NW-1:0] rmd;
  logic          div_busy;
  logic          out_valid_r, out_valid_nxt;
  logic [pf_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic          last_r, last_nxt;
  logic          none_r, none_nxt;
  logic          emit;

  pf_divu #(.NW(NW)) u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctl.act == pf_pkg::ACT_DIV_GO),
    .dividend (rem_r),
    .divisor  (div_r),
    .busy     (div_busy),
    .quo      (quo),
    .rmd      (rmd)
  );

  // status back to the sequencer
  always_comb begin
    stat.out_free   = !out_valid_r || out_ready;
    stat.div_busy   = div_busy;
    stat.rem_le1    = (rem_r <= NW'(1));
    stat.div_gt_quo = (div_r > quo);
    stat.mod_zero   = (rmd == '0);
  end

  assign emit = (ctl.act == pf_pkg::ACT_EMIT_DIV) || (ctl.act == pf_pkg::ACT_EMIT_NONE) ||
                (ctl.act == pf_pkg::ACT_EMIT_REM);

  // action decode
  always_comb begin
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    factor_nxt = factor_r;
    last_nxt   = last_r;
    none_nxt   = none_r;
    unique case (ctl.act)
      pf_pkg::ACT_LOAD: begin
        rem_nxt = value_in[NW-1:0];
        div_nxt = NW'(2);
      end
      pf_pkg::ACT_INC_DIV: begin
        div_nxt = div_r + NW'(1);
      end
      pf_pkg::ACT_EMIT_DIV: begin
        rem_nxt    = quo;
        factor_nxt = pf_pkg::FACTOR_W'(div_r);
        last_nxt   = 1'b0;
        none_nxt   = 1'b0;
      end
      pf_pkg::ACT_EMIT_NONE: begin
        factor_nxt = '0;
        last_nxt   = 1'b1;
        none_nxt   = 1'b1;
      end
      pf_pkg::ACT_EMIT_REM: begin
        factor_nxt = pf_pkg::FACTOR_W'(rem_r);
        last_nxt   = 1'b1;
        none_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result slot: filled on emit, freed when the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    factor_r <= factor_nxt;
    last_r   <= last_nxt;
    none_r   <= none_nxt;
  end

  assign out_valid = out_valid_r;
  assign factor    = factor_r;
  assign last      = last_r;
  assign none      = none_r;

  `PF_ASSERT_NOW(a_none_shape, clk, rst_n, out_valid_r && none_r,
                 last_r && (factor_r == '0), "empty result not marked last with zero factor")
  `PF_ASSERT_NOW(a_factor_ge2, clk, rst_n, out_valid_r && !none_r,
                 factor_r >= pf_pkg::FACTOR_W'(2), "factor below two emitted")

endmodule

### rtl/core/pf_seq.sv
// Microcode sequencer: step counter, control store lookup, hold and jump.
// Depends on pf_pkg.
`timescale 1ns / 1ps

module pf_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pf_pkg::stat_t stat,
  output pf_pkg::ctl_t  ctl
);

  logic [pf_pkg::UPC_W-1:0] upc_r, upc_nxt;
  pf_pkg::uword_t           w;
  logic                     wait_ok;
  logic                     cond_ok;

  always_comb w = pf_pkg::ucode_rom(upc_r);

  // hold condition
  always_comb begin
    unique case (w.wt)
      pf_pkg::WAIT_NONE: wait_ok = 1'b1;
      pf_pkg::WAIT_IN:   wait_ok = in_valid;
      pf_pkg::WAIT_DIV:  wait_ok = !stat.div_busy;
      pf_pkg::WAIT_OUT:  wait_ok = stat.out_free;
      default:           wait_ok = 1'b0;
    endcase
  end

  // jump condition
  always_comb begin
    unique case (w.cond)
      pf_pkg::COND_NEVER:      cond_ok = 1'b0;
      pf_pkg::COND_ALWAYS:     cond_ok = 1'b1;
      pf_pkg::COND_REM_LE1:    cond_ok = stat.rem_le1;
      pf_pkg::COND_DIV_GT_QUO: cond_ok = stat.div_gt_quo;
      pf_pkg::COND_MOD_ZERO:   cond_ok = stat.mod_zero;
      default:                 cond_ok = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (wait_ok) begin
      upc_nxt = cond_ok ? w.target : upc_r + pf_pkg::UPC_W'(1);
    end
  end

  always_comb begin
    ctl.act  = wait_ok ? w.act : pf_pkg::ACT_NOP;
    ctl.take = (w.wt == pf_pkg::WAIT_IN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= pf_pkg::STEP_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### dv/tb.sv
// Self-checking testbench for prime_factorizer: directed table then random values,
// with every factor word checked against a table row or a trial-division predictor.
// Depends on pf_pkg, pf_chan_if and the prime_factorizer RTL.
`timescale 1ns / 1ps

module tb;

  localparam int DUT_WIDTH = 32;
  localparam longint unsigned VALUE_MASK =
    (DUT_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << DUT_WIDTH) - 64'd1);
  localparam int RUN_MAX       = 32;      // most factor words per value
  localparam int QUIET_LIMIT   = 100000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_VALUES = 80;
  localparam int NUM_DIRECTED  = 19;
  localparam int NUM_PRIMES    = 31;

  // one result word as seen on out_chan
  typedef struct packed {
    logic [pf_pkg::FACTOR_W-1:0] factor;
    logic                        last;
    logic                        none;
  } factor_word_t;

  // directed row; known rows carry their factor list, the rest go to the predictor
  typedef struct packed {
    logic [pf_pkg::IN_W-1:0]              value;
    logic                                 known;
    logic                                 none;
    logic [2:0]                           n;
    logic [0:4][pf_pkg::FACTOR_W-1:0]     f;
  } plan_row_t;

  localparam int unsigned SMALL_PRIMES [NUM_PRIMES] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53,
    59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127
  };

  plan_row_t plan [NUM_DIRECTED] = '{
    '{32'd0,          1'b1, 1'b1, 3'd1, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd1,          1'b1, 1'b1, 3'd1, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd2,          1'b1, 1'b0, 3'd1, '{32'd2, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd3,          1'b1, 1'b0, 3'd1, '{32'd3, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd4,          1'b1, 1'b0, 3'd2, '{32'd2, 32'd2, 32'd0, 32'd0, 32'd0}},
    '{32'd6,          1'b1, 1'b0, 3'd2, '{32'd2, 32'd3, 32'd0, 32'd0, 32'd0}},
    '{32'd63001,      1'b1, 1'b0, 3'd2, '{32'd251, 32'd251, 32'd0, 32'd0, 32'd0}},
    '{32'd65521,      1'b1, 1'b0, 3'd1, '{32'd65521, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd65537,      1'b1, 1'b0, 3'd1, '{32'd65537, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'hFFFF_FFFF,  1'b1, 1'b0, 3'd5, '{32'd3, 32'd5, 32'd17, 32'd257, 32'd65537}},
    '{32'hAAAA_AAAA,  1'b1, 1'b0, 3'd5, '{32'd2, 32'd5, 32'd17, 32'd257, 32'd65537}},
    '{32'h5555_5555,  1'b1, 1'b0, 3'd4, '{32'd5, 32'd17, 32'd257, 32'd65537, 32'd0}},
    '{32'h8000_0000,  1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'hFFFF_0000,  1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'h7FFF_8000,  1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd8633,       1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd360,        1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'd9699690,    1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{32'h0001_0000,  1'b0, 1'b0, 3'd0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  pf_in_if  in_ch ();
  pf_out_if out_ch ();

  prime_factorizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  factor_word_t pending_factors [$];
  int mismatches    = 0;
  int values_sent   = 0;
  int words_checked = 0;
  int none_words    = 0;
  int run_len       = 0;
  int longest_run   = 0;
  int burst_left    = 0;
  int quiet_cycles  = 0;
  int unsigned stall_cycle = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // trial division, smallest divisor first, queued as expected words
  function automatic void predict_factors(input logic [pf_pkg::IN_W-1:0] v);
    longint unsigned rem;
    longint unsigned dv;
    int count;
    factor_word_t w;
    rem = longint'(v) & VALUE_MASK;
    if (rem <= 1) begin
      w = '{factor: '0, last: 1'b1, none: 1'b1};
      pending_factors.push_back(w);
      return;
    end
    dv = 2;
    count = 0;
    while (dv <= rem / dv && count < RUN_MAX) begin
      if (rem % dv == 0) begin
        rem = rem / dv;
        w = '{factor: pf_pkg::FACTOR_W'(dv), last: 1'b0, none: 1'b0};
        pending_factors.push_back(w);
        count++;
      end else begin
        dv++;
      end
    end
    // whatever is left above one is prime
    if (rem > 1 && count < RUN_MAX) begin
      w = '{factor: pf_pkg::FACTOR_W'(rem), last: 1'b0, none: 1'b0};
      pending_factors.push_back(w);
    end
    pending_factors[pending_factors.size() - 1].last = 1'b1;
  endfunction

  // sender bursts: lower valid only when a real gap follows
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(8, 1);
    end
    burst_left--;
  endtask

  // present one word and hold it until the block takes it
  task automatic offer_value(input logic [pf_pkg::IN_W-1:0] v);
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    do @(posedge clk); while (!in_ch.ready);
    values_sent++;
  endtask

  // hold off the sender until every expected word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_factors.size() != 0);
  endtask

  // smooth value: cofactor below 2^14 times primes below 128, kept within 32 bits
  function automatic logic [pf_pkg::IN_W-1:0] smooth_value();
    longint unsigned v;
    longint unsigned p;
    int k;
    v = $urandom_range(16383, 0);
    k = $urandom_range(30, 0);
    for (int i = 0; i < k && v != 0; i++) begin
      p = SMALL_PRIMES[$urandom_range(NUM_PRIMES - 1, 0)];
      if (v * p > 64'hFFFF_FFFF) break;
      v = v * p;
    end
    return pf_pkg::IN_W'(v);
  endfunction

  // receiver stalls: the pattern is picked by bits 9:8 of a free-running cycle counter
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_cycle[9:8])
        2'd0: out_ch.ready <= 1'b1;
        2'd1: out_ch.ready <= $urandom_range(1, 0) == 1;
        2'd2: out_ch.ready <= stall_cycle[2:0] == 3'd0;
        default: out_ch.ready <= $urandom_range(3, 0) != 0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_words
    factor_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (out_ch.none) none_words++;
      run_len++;
      if (out_ch.last) begin
        if (run_len > longest_run) longest_run = run_len;
        run_len = 0;
      end
      if (pending_factors.size() == 0) begin
        report_mismatch($sformatf("unexpected word factor=%0d last=%0b none=%0b",
                                  out_ch.factor, out_ch.last, out_ch.none));
      end else begin
        want = pending_factors.pop_front();
        if (out_ch.factor !== want.factor)
          report_mismatch($sformatf("factor %0d, expected %0d", out_ch.factor, want.factor));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (factor %0d)",
                                    out_ch.last, want.last, want.factor));
        if (out_ch.none !== want.none)
          report_mismatch($sformatf("none %0b, expected %0b (factor %0d)",
                                    out_ch.none, want.none, want.factor));
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d still expected",
                 QUIET_LIMIT, pending_factors.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    factor_word_t w;
    logic [pf_pkg::IN_W-1:0] v;
    int pick;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.value_in <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: zero/one, primes, extremes, repeated factors
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      pace_sender();
      offer_value(plan[r].value);
      if (plan[r].known) begin
        for (int i = 0; i < plan[r].n; i++) begin
          w.factor = plan[r].f[i];
          w.none   = plan[r].none;
          w.last   = (i == plan[r].n - 1);
          pending_factors.push_back(w);
        end
      end else begin
        predict_factors(plan[r].value);
      end
    end
    wait_drained();

    // random values, mostly smooth numbers with a bounded last cofactor
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      pick = $urandom_range(9, 0);
      if (pick == 0)      v = pf_pkg::IN_W'($urandom_range(3, 0));
      else if (pick == 1) v = pf_pkg::IN_W'($urandom_range(16383, 0));
      else                v = smooth_value();
      pace_sender();
      offer_value(v);
      predict_factors(v);
      if (n == RANDOM_VALUES / 2) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d values (%0d from the table), %0d factor words checked,",
             values_sent, NUM_DIRECTED, words_checked);
    $display("%0d zero/one words, longest run %0d words, under bursty input and stalls",
             none_words, longest_run);
    if (mismatches == 0 && pending_factors.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, pending_factors.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pf_pkg.sv
rtl/core/pf_chan_if.sv
rtl/core/pf_divu.sv
rtl/core/pf_dp.sv
rtl/core/pf_seq.sv
rtl/core/prime_factorizer.sv
dv/tb.sv
